>>> rtl/core/mpm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the modular matrix power block.
// No dependencies; mpm_modred and matrix_power_mod import this package.
package mpm_pkg;

   localparam int VAL_W       = 31;
   localparam int EXP_W       = 63;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int ROWCOL_W    = 6;
   localparam int SIZE_W      = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int DEFAULT_MAX_DIM = 64;

   localparam logic [SIZE_W-1:0] RESET_SIZE    = 7'd1;
   localparam logic [VAL_W-1:0]  RESET_MODULUS = 31'd1000000007;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_POWER = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE    = 1'b0,
      CSR_MODULUS = 1'b1
   } csr_idx_type;

endpackage

>>> rtl/core/mpm_ram.sv
`timescale 1ns / 1ps
// Synchronous matrix store: one write port, one or more read ports, registered read data.
// Depends on nothing but its parameters.
module mpm_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 31,
   parameter int RD_N   = 1
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [ADDR_W-1:0]           waddr,
   input  logic [DATA_W-1:0]           wdata,
   input  logic [RD_N-1:0][ADDR_W-1:0] raddr,
   output logic [RD_N-1:0][DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      for (int p = 0; p < RD_N; p++) begin
         rdata[p] <= mem[raddr[p]];
      end
   end

endmodule

>>> rtl/core/mpm_modred.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: x mod m, one dividend bit per cycle.
// Depends on mpm_pkg for the operand widths.
module mpm_modred
   import mpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] x,
   input  logic [VAL_W-1:0] m,
   output logic             busy,
   output logic             done,
   output logic [VAL_W-1:0] rem
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] x_ff, x_in;
   logic [VAL_W-1:0] r_ff, r_in;
   logic [VAL_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      trial   = {r_ff, x_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         x_in    = x;
         r_in    = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below m, so one subtract suffices.
         if (trial >= {1'b0, m}) begin
            r_in = VAL_W'(trial - {1'b0, m});
         end else begin
            r_in = trial[VAL_W-1:0];
         end
         x_in   = {x_ff[SUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = r_ff;

endmodule

>>> rtl/core/matrix_power_mod.sv
`timescale 1ns / 1ps
// Top level of the modular matrix power block: sequencer, configuration and stores.
// Depends on mpm_pkg, mpm_ram and mpm_modred.
//
//   Channel   Direction  Handshake            Carries
//   req_*     in         req_valid/req_ready  operation, row, col, entry value, exponent
//   rsp_*     out        rsp_valid/rsp_ready  read value, done flag
//   csr_*     in         csr_we               matrix size (index 0), modulus (index 1)
//
// Operations: an entry write whose value is already below the modulus goes straight into
// the base store; a write that needs reduction waits on the remainder unit. A clear sweeps
// the whole base store. A power first loads the identity into the result and the base into
// the running square, then forms each matrix product term by term, running the serial
// remainder unit once for each multiply-accumulate term, and copies the product back. Up to two products per
// exponent bit. Reset starts the same clearing sweep, during which no request is taken.
// A waiting response holds off new requests; once taken, the next request is accepted.
module matrix_power_mod
   import mpm_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [ROWCOL_W-1:0]  req_row,
   input  logic [ROWCOL_W-1:0]  req_col,
   input  logic [VAL_W-1:0]     req_entry_value,
   input  logic [EXP_W-1:0]     req_exponent,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_read_value,
   output logic                 rsp_done_res,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wdata
);

   localparam int LOG = $clog2(MAX_DIM);
   localparam int AW  = 2 * LOG;
   localparam int DW  = $clog2(MAX_DIM + 1);
   localparam int RW  = (LOG > ROWCOL_W) ? LOG : ROWCOL_W;

   // One-hot sequencer states.
   typedef enum logic [12:0] {
      ST_CLEAR   = 13'b0000000000001,
      ST_IDLE    = 13'b0000000000010,
      ST_WMOD    = 13'b0000000000100,
      ST_READ    = 13'b0000000001000,
      ST_INIT_RD = 13'b0000000010000,
      ST_INIT_WR = 13'b0000000100000,
      ST_STEP    = 13'b0000001000000,
      ST_MRD     = 13'b0000010000000,
      ST_MMUL    = 13'b0000100000000,
      ST_MADD    = 13'b0001000000000,
      ST_MDIV    = 13'b0010000000000,
      ST_CP_RD   = 13'b0100000000000,
      ST_CP_WR   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [SIZE_W-1:0] size_ff;
   logic [VAL_W-1:0]  mod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= RESET_SIZE;
         mod_ff  <= RESET_MODULUS;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SIZE:    size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_MODULUS: mod_ff  <= csr_wdata;
            default:     mod_ff  <= mod_ff;
         endcase
      end
   end

   // Effective modulus and side length: a zero modulus acts as one, and the size is
   // clamped into one to MAX_DIM.
   logic [VAL_W-1:0] m_eff;
   logic [DW-1:0]    dim;
   logic [DW-1:0]    dim_m1;
   logic [LOG-1:0]   last_idx;

   assign m_eff = (mod_ff == '0) ? VAL_W'(1) : mod_ff;

   always_comb begin
      if (size_ff == '0) begin
         dim = DW'(1);
      end else if (32'(size_ff) > 32'(MAX_DIM)) begin
         dim = DW'(MAX_DIM);
      end else begin
         dim = DW'(size_ff);
      end
   end

   assign dim_m1   = dim - DW'(1);
   assign last_idx = dim_m1[LOG-1:0];

   // Request decode.
   op_type           req_op;
   logic [RW-1:0]    row_x, col_x;
   logic [AW-1:0]    req_addr;
   logic             req_in_max, req_in_dim, req_fast;
   logic             accept;

   assign req_op     = op_type'(req_operation);
   assign row_x      = RW'(req_row);
   assign col_x      = RW'(req_col);
   assign req_addr   = {row_x[LOG-1:0], col_x[LOG-1:0]};
   assign req_in_max = (32'(req_row) < 32'(MAX_DIM)) && (32'(req_col) < 32'(MAX_DIM));
   assign req_in_dim = (32'(req_row) < 32'(dim)) && (32'(req_col) < 32'(dim));
   assign req_fast   = req_entry_value < m_eff;

   // Sequencer registers.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_free;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic [LOG-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [EXP_W-1:0] e_ff, e_in;
   logic             sq_ff, sq_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [AW-1:0]    wa_ff, wa_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   // Store ports.
   logic             base_we, res_we, scr_we, prd_we;
   logic [AW-1:0]    base_waddr, res_waddr, scr_waddr, prd_waddr;
   logic [VAL_W-1:0] base_wdata, res_wdata, scr_wdata, prd_wdata;
   logic [AW-1:0]    res_raddr;
   logic [VAL_W-1:0] base_rd, res_rd, scr_rd0, scr_rd1, prd_rd;
   logic [AW-1:0]    addr_ij, addr_ik, addr_kj;
   logic [1:0][AW-1:0]    scr_raddr;
   logic [1:0][VAL_W-1:0] scr_rd;

   assign addr_ij = {i_ff, j_ff};
   assign addr_ik = {i_ff, k_ff};
   assign addr_kj = {k_ff, j_ff};

   // The running square is read twice per term: row i at port 0, column j at port 1.
   assign scr_raddr = {addr_kj, addr_ik};
   assign scr_rd0   = scr_rd[0];
   assign scr_rd1   = scr_rd[1];

   // Remainder unit.
   logic             mr_start, mr_busy, mr_done;
   logic [SUM_W-1:0] mr_x;
   logic [VAL_W-1:0] mr_rem;

   // Identity diagonal value: one, or zero under a modulus of one.
   logic [VAL_W-1:0] one_mod;
   assign one_mod = (m_eff == VAL_W'(1)) ? '0 : VAL_W'(1);

   logic i_last, j_last, k_last;
   assign i_last = (i_ff == last_idx);
   assign j_last = (j_ff == last_idx);
   assign k_last = (k_ff == last_idx);

   // Factor operands of the current term: the left factor is the result matrix, or the
   // running square when squaring; the right factor is always the running square.
   logic [VAL_W-1:0] fac_a, fac_b;
   assign fac_a = sq_ff ? scr_rd0 : res_rd;
   assign fac_b = scr_rd1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      clr_rsp_in   = clr_rsp_ff;
      sweep_in     = sweep_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      sq_in        = sq_ff;
      rd_ok_in     = rd_ok_ff;
      wa_in        = wa_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;

      base_we    = 1'b0;
      base_waddr = req_addr;
      base_wdata = req_entry_value;
      res_we     = 1'b0;
      res_waddr  = addr_ij;
      res_wdata  = prd_rd;
      scr_we     = 1'b0;
      scr_waddr  = addr_ij;
      scr_wdata  = prd_rd;
      prd_we     = 1'b0;
      prd_waddr  = addr_ij;
      prd_wdata  = mr_rem;
      res_raddr  = addr_ik;
      mr_start   = 1'b0;
      mr_x       = SUM_W'(req_entry_value);

      unique case (state_ff)
         ST_CLEAR: begin
            base_we    = 1'b1;
            base_waddr = sweep_ff;
            base_wdata = '0;
            sweep_in   = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
               end
            end
         end
         ST_IDLE: begin
            res_raddr = req_addr;
            if (accept) begin
               unique case (req_op)
                  OP_WRITE: begin
                     // In-range values go straight in; larger ones need a reduction.
                     if (req_in_max && !req_fast) begin
                        mr_start = 1'b1;
                        wa_in    = req_addr;
                        state_in = ST_WMOD;
                     end else begin
                        base_we      = req_in_max;
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                     end
                  end
                  OP_POWER: begin
                     e_in     = req_exponent;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_INIT_RD;
                  end
                  OP_READ: begin
                     rd_ok_in = req_in_dim;
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WMOD: begin
            if (mr_done) begin
               base_we      = 1'b1;
               base_waddr   = wa_ff;
               base_wdata   = mr_rem;
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_ok_ff ? res_rd : '0;
            state_in     = ST_IDLE;
         end
         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            // Result starts as the identity, the running square as the base.
            res_we    = 1'b1;
            res_wdata = (i_ff == j_ff) ? one_mod : '0;
            scr_we    = 1'b1;
            scr_wdata = base_rd;
            state_in  = ST_INIT_RD;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in = ST_STEP;
               end else begin
                  i_in = i_ff + LOG'(1);
               end
            end else begin
               j_in = j_ff + LOG'(1);
            end
         end
         ST_STEP: begin
            // Square-and-multiply: a set low bit multiplies into the result and is
            // cleared; otherwise the exponent shifts and the square is taken if bits remain.
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            acc_in = '0;
            if (e_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               state_in     = ST_IDLE;
            end else if (e_ff[0]) begin
               e_in     = {e_ff[EXP_W-1:1], 1'b0};
               sq_in    = 1'b0;
               state_in = ST_MRD;
            end else begin
               e_in = e_ff >> 1;
               if ((e_ff >> 1) != '0) begin
                  sq_in    = 1'b1;
                  state_in = ST_MRD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_MRD: begin
            state_in = ST_MMUL;
         end
         ST_MMUL: begin
            prod_in  = PROD_W'(fac_a) * PROD_W'(fac_b);
            state_in = ST_MADD;
         end
         ST_MADD: begin
            mr_start = 1'b1;
            mr_x     = SUM_W'(prod_ff) + SUM_W'(acc_ff);
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            if (mr_done) begin
               acc_in   = mr_rem;
               state_in = ST_MRD;
               if (k_last) begin
                  prd_we = 1'b1;
                  acc_in = '0;
                  k_in   = '0;
                  if (j_last) begin
                     j_in = '0;
                     if (i_last) begin
                        i_in     = '0;
                        state_in = ST_CP_RD;
                     end else begin
                        i_in = i_ff + LOG'(1);
                     end
                  end else begin
                     j_in = j_ff + LOG'(1);
                  end
               end else begin
                  k_in = k_ff + LOG'(1);
               end
            end
         end
         ST_CP_RD: begin
            state_in = ST_CP_WR;
         end
         ST_CP_WR: begin
            res_we   = !sq_ff;
            scr_we   = sq_ff;
            state_in = ST_CP_RD;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in = ST_STEP;
               end else begin
                  i_in = i_ff + LOG'(1);
               end
            end else begin
               j_in = j_ff + LOG'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         sweep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_rsp_ff   <= clr_rsp_in;
         sweep_ff     <= sweep_in;
      end
      rsp_value_ff <= rsp_value_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      e_ff         <= e_in;
      sq_ff        <= sq_in;
      rd_ok_ff     <= rd_ok_in;
      wa_ff        <= wa_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_done_res   = 1'b1;

   // The sequencer never uses a read of a store entry written in the same step,
   // so the stores need no forwarding: every read it uses has its own state ahead of the write.
   mpm_ram #(.ADDR_W(AW), .DATA_W(VAL_W), .RD_N(1)) u_base (
      .clock  (clock),
      .we     (base_we),
      .waddr  (base_waddr),
      .wdata  (base_wdata),
      .raddr  (addr_ij),
      .rdata  (base_rd)
   );

   mpm_ram #(.ADDR_W(AW), .DATA_W(VAL_W), .RD_N(1)) u_result (
      .clock  (clock),
      .we     (res_we),
      .waddr  (res_waddr),
      .wdata  (res_wdata),
      .raddr  (res_raddr),
      .rdata  (res_rd)
   );

   mpm_ram #(.ADDR_W(AW), .DATA_W(VAL_W), .RD_N(2)) u_scratch (
      .clock  (clock),
      .we     (scr_we),
      .waddr  (scr_waddr),
      .wdata  (scr_wdata),
      .raddr  (scr_raddr),
      .rdata  (scr_rd)
   );

   mpm_ram #(.ADDR_W(AW), .DATA_W(VAL_W), .RD_N(1)) u_product (
      .clock  (clock),
      .we     (prd_we),
      .waddr  (prd_waddr),
      .wdata  (prd_wdata),
      .raddr  (addr_ij),
      .rdata  (prd_rd)
   );

   mpm_modred u_modred (
      .clock (clock),
      .reset (reset),
      .start (mr_start),
      .x     (mr_x),
      .m     (m_eff),
      .busy  (mr_busy),
      .done  (mr_done),
      .rem   (mr_rem)
   );

`ifndef ASSERT_OFF
   // Only the idle state may leave a response waiting; long operations start with it empty.
   a_rsp_only_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending outside idle");

   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_modred_free : assert property (@(posedge clock) disable iff (reset)
      mr_start |-> !mr_busy)
      else $error("remainder unit restarted while busy");

   a_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      mr_done |-> (state_ff == ST_MDIV || state_ff == ST_WMOD))
      else $error("remainder result arrived outside a wait state");
`endif

endmodule
